[rtl/core/fkurt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame kurtosis package
// Types, widths and helpers shared by the frame kurtosis core and its
// arithmetic unit.
// ----------------------------------------------------------------------------
package fkurt_pkg;

  localparam int MAX_FRAME   = 1024;
  localparam int SAMPLE_BITS = 12;
  localparam int SAMPLE_W    = 12;
  localparam int ADDR_W      = $clog2(MAX_FRAME);
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int SUM_W       = 23;
  localparam int MDIV_W      = SUM_W + 1;
  localparam int DEN_W       = CNT_W + 1;
  localparam int MEAN_W      = SAMPLE_W + 1;
  localparam int DIFF_W      = SAMPLE_W + 2;
  localparam int AD_W        = SAMPLE_W;
  localparam int D2_W        = 2 * AD_W;
  localparam int D4_W        = 2 * D2_W;
  localparam int SUM2_W      = 35;
  localparam int SUM4_W      = 59;
  localparam int FRAC_BITS   = 16;
  localparam int KURT_W      = 27;
  localparam int ALU_W       = 2 * SUM2_W + KURT_W - 1;
  localparam int STEP_W      = 6;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_beat_t;

  typedef struct packed {
    logic [KURT_W-1:0] kurtosis_value;
    logic              degenerate;
    logic              overflowed;
  } out_beat_t;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             carry;
  } alu_res_t;

  function automatic logic signed [SAMPLE_W-1:0] extend_sample(
    input logic [SAMPLE_W-1:0] raw
  );
    logic signed [SAMPLE_W-1:0] sh;
    sh = $signed(raw << (SAMPLE_W - SAMPLE_BITS));
    return sh >>> (SAMPLE_W - SAMPLE_BITS);
  endfunction

endpackage

[rtl/core/fkurt_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame kurtosis shared adder
// Wide add or subtract with carry out; with subtraction the carry means the
// first operand is not below the second.
// ----------------------------------------------------------------------------
module fkurt_alu (
  input  fkurt_pkg::alu_req_t req,
  output fkurt_pkg::alu_res_t res
);

  logic [fkurt_pkg::ALU_W:0] total;
  logic [fkurt_pkg::ALU_W-1:0] b_eff;

  assign b_eff = req.sub ? ~req.b : req.b;
  assign total = {1'b0, req.a} + {1'b0, b_eff}
               + {{fkurt_pkg::ALU_W{1'b0}}, req.sub};

  assign res.value = total[fkurt_pkg::ALU_W-1:0];
  assign res.carry = total[fkurt_pkg::ALU_W];

endmodule

[rtl/core/frame_kurtosis_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame kurtosis top level
// Samples load at one beat per cycle while the block is not busy. After
// the last beat of a frame of n stored samples the block stays busy until
// it strobes its result, sooner for a flat frame; n is at most 1024.
// The pace is set by the single shared adder: a 24-step mean divider, a
// square and a fourth-power step per sample, 11 + 35 shift-add steps and
// a 27-step restoring divide. Synchronous reset empties the frame and idles.
// ----------------------------------------------------------------------------
module frame_kurtosis_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  fkurt_pkg::in_beat_t  in_data,
  output logic                 out_valid,
  output fkurt_pkg::out_beat_t out_data
);

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_MSET = 4'd1;
  localparam logic [3:0] S_MDIV = 4'd2;
  localparam logic [3:0] S_MFIX = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_SQ   = 4'd5;
  localparam logic [3:0] S_QU   = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_NMUL = 4'd8;
  localparam logic [3:0] S_DSET = 4'd9;
  localparam logic [3:0] S_DMUL = 4'd10;
  localparam logic [3:0] S_TSET = 4'd11;
  localparam logic [3:0] S_DIV  = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  localparam int ALU_W  = fkurt_pkg::ALU_W;
  localparam int STEP_W = fkurt_pkg::STEP_W;

  logic [3:0] state_r, state_nxt;
  logic [fkurt_pkg::CNT_W-1:0] count_r, count_nxt;
  logic signed [fkurt_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic ovf_r, ovf_nxt;
  logic degen_r, degen_nxt;
  logic neg_r, neg_nxt;
  logic [fkurt_pkg::DEN_W-1:0] den_r, den_nxt;
  logic [fkurt_pkg::DEN_W-2:0] rem_r, rem_nxt;
  logic [fkurt_pkg::MDIV_W-1:0] quo_r, quo_nxt;
  logic [fkurt_pkg::MEAN_W-1:0] mean_r, mean_nxt;
  logic [fkurt_pkg::ADDR_W-1:0] idx_r, idx_nxt;
  logic [fkurt_pkg::D2_W-1:0] d2_r, d2_nxt;
  logic [fkurt_pkg::SUM2_W-1:0] sum2_r, sum2_nxt;
  logic [fkurt_pkg::SUM4_W-1:0] sum4_r, sum4_nxt;
  logic [ALU_W-1:0] acc_r, acc_nxt;
  logic [ALU_W-1:0] mcand_r, mcand_nxt;
  logic [ALU_W-1:0] num_r, num_nxt;
  logic [fkurt_pkg::SUM2_W-1:0] mplier_r, mplier_nxt;
  logic [fkurt_pkg::KURT_W-1:0] q_r, q_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic out_valid_r, out_valid_nxt;
  fkurt_pkg::out_beat_t out_data_r, out_data_nxt;

  logic [fkurt_pkg::SAMPLE_W-1:0] mem [fkurt_pkg::MAX_FRAME];
  logic [fkurt_pkg::SAMPLE_W-1:0] rdata_r;
  logic [fkurt_pkg::ADDR_W-1:0] rd_addr;

  logic accept;
  logic load_we;
  logic signed [fkurt_pkg::SAMPLE_W-1:0] sample_ext;
  logic [fkurt_pkg::MDIV_W-1:0] mset_num;
  logic [fkurt_pkg::DEN_W-1:0] mset_den;
  logic [fkurt_pkg::DEN_W-1:0] rem_shift;
  logic signed [fkurt_pkg::DIFF_W-1:0] d_full;
  logic [fkurt_pkg::DIFF_W-1:0] ad_full;
  logic [fkurt_pkg::D2_W-1:0] mul_op;
  logic [fkurt_pkg::D4_W-1:0] prod;
  logic pass_done;
  fkurt_pkg::alu_req_t alu_req;
  fkurt_pkg::alu_res_t alu_res;

  fkurt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign busy      = (state_r != S_LOAD);
  assign accept    = start && !busy;
  assign load_we   = accept && (count_r < fkurt_pkg::CNT_W'(fkurt_pkg::MAX_FRAME));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sample_ext = fkurt_pkg::extend_sample(in_data.sample);
  assign mset_num   = {sum_r, 1'b0} + fkurt_pkg::MDIV_W'(count_r);
  assign mset_den   = {count_r, 1'b0};
  assign rem_shift  = {rem_r, quo_r[fkurt_pkg::MDIV_W-1]};
  assign d_full     = $signed({{2{rdata_r[fkurt_pkg::SAMPLE_W-1]}}, rdata_r})
                    - $signed({mean_r[fkurt_pkg::MEAN_W-1], mean_r});
  assign ad_full    = d_full[fkurt_pkg::DIFF_W-1] ? (~d_full + 1'b1) : d_full;
  assign mul_op     = (state_r == S_SQ) ?
                      fkurt_pkg::D2_W'(ad_full[fkurt_pkg::AD_W-1:0]) : d2_r;
  assign prod       = mul_op * mul_op;
  assign pass_done  = ({1'b0, idx_r} == (count_r - fkurt_pkg::CNT_W'(1)));
  assign rd_addr    = (state_r == S_PREP) ? '0 : idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[count_r[fkurt_pkg::ADDR_W-1:0]] <= sample_ext;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    alu_req.sub = 1'b0;
    alu_req.a   = acc_r;
    alu_req.b   = mcand_r;
    unique case (state_r)
      S_MDIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = ALU_W'(rem_shift);
        alu_req.b   = ALU_W'(den_r);
      end
      S_QU: begin
        alu_req.a = ALU_W'(sum4_r);
        alu_req.b = ALU_W'(prod);
      end
      S_DIV: begin
        alu_req.sub = 1'b1;
        alu_req.a   = num_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    ovf_nxt       = ovf_r;
    degen_nxt     = degen_r;
    neg_nxt       = neg_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    mean_nxt      = mean_r;
    idx_nxt       = idx_r;
    d2_nxt        = d2_r;
    sum2_nxt      = sum2_r;
    sum4_nxt      = sum4_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    num_nxt       = num_r;
    mplier_nxt    = mplier_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (load_we) begin
            count_nxt = count_r + fkurt_pkg::CNT_W'(1);
            sum_nxt   = sum_r + fkurt_pkg::SUM_W'(sample_ext);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            state_nxt = S_MSET;
          end
        end
      end
      S_MSET: begin
        q_nxt     = '0;
        degen_nxt = (count_r == '0);
        neg_nxt   = mset_num[fkurt_pkg::MDIV_W-1];
        den_nxt   = mset_den;
        rem_nxt   = '0;
        quo_nxt   = mset_num[fkurt_pkg::MDIV_W-1] ?
                    (~mset_num + fkurt_pkg::MDIV_W'(mset_den)) : mset_num;
        step_nxt  = '0;
        state_nxt = (count_r == '0) ? S_EMIT : S_MDIV;
      end
      S_MDIV: begin
        rem_nxt  = alu_res.carry ? alu_res.value[fkurt_pkg::DEN_W-2:0]
                                 : rem_shift[fkurt_pkg::DEN_W-2:0];
        quo_nxt  = {quo_r[fkurt_pkg::MDIV_W-2:0], alu_res.carry};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(fkurt_pkg::MDIV_W - 1)) begin
          state_nxt = S_MFIX;
        end
      end
      S_MFIX: begin
        mean_nxt  = neg_r ? (~quo_r[fkurt_pkg::MEAN_W-1:0] + 1'b1)
                          : quo_r[fkurt_pkg::MEAN_W-1:0];
        state_nxt = S_PREP;
      end
      S_PREP: begin
        idx_nxt   = '0;
        sum2_nxt  = '0;
        sum4_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        d2_nxt    = prod[fkurt_pkg::D2_W-1:0];
        state_nxt = S_QU;
      end
      S_QU: begin
        sum4_nxt = alu_res.value[fkurt_pkg::SUM4_W-1:0];
        sum2_nxt = sum2_r + fkurt_pkg::SUM2_W'(d2_r);
        idx_nxt  = idx_r + 1'b1;
        state_nxt = pass_done ? S_CHK : S_SQ;
      end
      S_CHK: begin
        degen_nxt  = (sum2_r == '0);
        acc_nxt    = '0;
        mcand_nxt  = ALU_W'(sum4_r) << fkurt_pkg::FRAC_BITS;
        mplier_nxt = fkurt_pkg::SUM2_W'(count_r);
        step_nxt   = '0;
        state_nxt  = (sum2_r == '0) ? S_EMIT : S_NMUL;
      end
      S_NMUL: begin
        if (mplier_r[0]) begin
          acc_nxt = alu_res.value;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(fkurt_pkg::CNT_W - 1)) begin
          state_nxt = S_DSET;
        end
      end
      S_DSET: begin
        num_nxt    = acc_r;
        acc_nxt    = '0;
        mcand_nxt  = ALU_W'(sum2_r);
        mplier_nxt = sum2_r;
        step_nxt   = '0;
        state_nxt  = S_DMUL;
      end
      S_DMUL: begin
        if (mplier_r[0]) begin
          acc_nxt = alu_res.value;
        end
        mcand_nxt  = mcand_r << 1;
        mplier_nxt = mplier_r >> 1;
        step_nxt   = step_r + 1'b1;
        if (step_r == STEP_W'(fkurt_pkg::SUM2_W - 1)) begin
          state_nxt = S_TSET;
        end
      end
      S_TSET: begin
        mcand_nxt = acc_r << (fkurt_pkg::KURT_W - 1);
        q_nxt     = '0;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (alu_res.carry) begin
          num_nxt = alu_res.value;
        end
        q_nxt     = {q_r[fkurt_pkg::KURT_W-2:0], alu_res.carry};
        mcand_nxt = mcand_r >> 1;
        step_nxt  = step_r + 1'b1;
        if (step_r == STEP_W'(fkurt_pkg::KURT_W - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_nxt               = 1'b1;
        out_data_nxt.kurtosis_value = degen_r ? '0 : q_r;
        out_data_nxt.degenerate     = degen_r;
        out_data_nxt.overflowed     = ovf_r;
        count_nxt                   = '0;
        sum_nxt                     = '0;
        ovf_nxt                     = 1'b0;
        state_nxt                   = S_LOAD;
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    degen_r    <= degen_nxt;
    neg_r      <= neg_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    mean_r     <= mean_nxt;
    idx_r      <= idx_nxt;
    d2_r       <= d2_nxt;
    sum2_r     <= sum2_nxt;
    sum4_r     <= sum4_nxt;
    acc_r      <= acc_nxt;
    mcand_r    <= mcand_nxt;
    num_r      <= num_nxt;
    mplier_r   <= mplier_nxt;
    q_r        <= q_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  // A result beat lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The block is back to loading when its result appears.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result emitted while still busy");

  // A degenerate frame reports a zero value.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.kurtosis_value == '0)
    else $error("degenerate result with nonzero value");

  // A sample that does not end the frame leaves the block ready.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_data.last |=> !busy)
    else $error("block went busy inside a frame");

endmodule
